// ===== src/row_softmax_unit_assert.svh =====
// ----------------------------------------------------------------------------
// row_softmax_unit_assert.svh
// Assertion macros for the row softmax block.
// ----------------------------------------------------------------------------
`ifndef ROW_SOFTMAX_UNIT_ASSERT_SVH
`define ROW_SOFTMAX_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define RSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RSM_ASSERT(lbl, cond)
`define RSM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared constants, types and the 2^(-k/16) table for the row softmax block.
// ----------------------------------------------------------------------------
`default_nettype none
package rsm_pkg;
    localparam int MAX_ROW  = 64;
    localparam int ADDR_W   = $clog2(MAX_ROW);
    localparam int CNT_W    = $clog2(MAX_ROW + 1);
    localparam int SAMPLE_W = 16;
    localparam int E_W      = 16;
    localparam int SUM_W    = $clog2(32768 * MAX_ROW + 1);
    localparam int NUM_W    = 32;
    localparam int QUO_W    = 17;
    localparam int PROB_W   = 16;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DIV_PUSH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [15:0]       m;
    } exp_req_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [E_W-1:0]    e;
    } exp_rsp_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [15:0] pow2_tab(input logic [4:0] k);
        logic [15:0] t;
        unique case (k)
            5'd0:    t = 16'd32768;
            5'd1:    t = 16'd31379;
            5'd2:    t = 16'd30048;
            5'd3:    t = 16'd28774;
            5'd4:    t = 16'd27554;
            5'd5:    t = 16'd26386;
            5'd6:    t = 16'd25268;
            5'd7:    t = 16'd24196;
            5'd8:    t = 16'd23170;
            5'd9:    t = 16'd22188;
            5'd10:   t = 16'd21247;
            5'd11:   t = 16'd20347;
            5'd12:   t = 16'd19484;
            5'd13:   t = 16'd18658;
            5'd14:   t = 16'd17867;
            5'd15:   t = 16'd17110;
            default: t = 16'd16384;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== src/row_softmax_unit.sv =====
// ----------------------------------------------------------------------------
// row_softmax_unit
// Softmax over one row of Q8.8 samples, Q0.16 probabilities out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries sample and row_end; one
//   transaction per row element. Elements load at one per cycle while the
//   block is in its load phase; the maximum is tracked on the fly. Elements
//   past 64 are dropped, but their row_end still closes the row.
//   On row_end the exp pass streams the row memory through a three-stage
//   exp pipeline; results go to a second memory and into the running sum.
//   Then each element goes through an e memory read, a bit-serial divide
//   and an output register load. in_ready is low from row_end until the
//   last probability of the row has entered the output register.
//   Output channel (out_valid/out_ready) is a single register; the last
//   probability carries last_out and may wait there while the next row loads.
//   A stalled receiver holds the divide pass at the push step.
//   Reset empties the row, sets the maximum to the most negative value and
//   clears the output valid flag; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "row_softmax_unit_assert.svh"
module row_softmax_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] sample,
    input  wire logic        row_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      prob,
    output logic             last_out
);
    localparam int AW = rsm_pkg::ADDR_W;
    localparam int CW = rsm_pkg::CNT_W;

    rsm_pkg::state_t state_reg, state_next;

    logic [CW-1:0]             fill_reg, fill_next;
    logic signed [15:0]        max_reg, max_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [AW-1:0]             div_idx_reg, div_idx_next;
    logic [rsm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      q_valid_reg;
    logic                      rd_en;

    // row memory and e memory
    logic [15:0]            row_mem [rsm_pkg::MAX_ROW];
    logic [rsm_pkg::E_W-1:0] e_mem  [rsm_pkg::MAX_ROW];
    logic signed [15:0]     row_q_reg;
    logic [AW-1:0]          q_idx_reg;
    logic [rsm_pkg::E_W-1:0] e_q_reg;
    logic [15:0]            prob_reg;
    logic                   last_reg;

    logic                 in_acc, out_take, store_ok;
    logic                 push;
    logic signed [16:0]   diff;
    logic [AW-1:0]        last_idx;

    rsm_pkg::exp_req_t exp_req;
    rsm_pkg::exp_rsp_t exp_rsp;
    rsm_pkg::div_req_t div_req;
    rsm_pkg::div_rsp_t div_rsp;

    assign in_ready  = (state_reg == rsm_pkg::ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign store_ok  = fill_reg < CW'(rsm_pkg::MAX_ROW);
    assign last_idx  = AW'(fill_reg - CW'(1));
    assign rd_en     = (state_reg == rsm_pkg::ST_EXP) && (rd_idx_reg < fill_reg);
    assign diff      = {max_reg[15], max_reg} - {row_q_reg[15], row_q_reg};
    assign push      = (state_reg == rsm_pkg::ST_DIV_PUSH) && (!out_valid_reg || out_ready);

    assign exp_req.valid = q_valid_reg;
    assign exp_req.idx   = q_idx_reg;
    assign exp_req.m     = diff[15:0];

    assign div_req.start = (state_reg == rsm_pkg::ST_DIV_GO);
    assign div_req.num   = {e_q_reg, 16'd0} + rsm_pkg::NUM_W'(sum_reg >> 1);
    assign div_req.den   = sum_reg;

    rsm_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exp_req),
        .rsp   (exp_rsp)
    );

    rsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        max_next       = max_reg;
        rd_idx_next    = rd_idx_reg;
        div_idx_next   = div_idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (push)
            out_valid_next = 1'b1;
        unique case (state_reg)
            rsm_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        fill_next = fill_reg + CW'(1);
                        if ($signed(sample) > max_reg)
                            max_next = $signed(sample);
                    end
                    if (row_end)
                    begin
                        state_next  = rsm_pkg::ST_EXP;
                        rd_idx_next = '0;
                        sum_next    = '0;
                    end
                end
            end
            rsm_pkg::ST_EXP:
            begin
                if (rd_en)
                    rd_idx_next = rd_idx_reg + CW'(1);
                if (exp_rsp.valid)
                begin
                    sum_next = sum_reg + rsm_pkg::SUM_W'(exp_rsp.e);
                    if (exp_rsp.idx == last_idx)
                    begin
                        state_next   = rsm_pkg::ST_DIV_RD;
                        div_idx_next = '0;
                    end
                end
            end
            rsm_pkg::ST_DIV_RD:   state_next = rsm_pkg::ST_DIV_GO;
            rsm_pkg::ST_DIV_GO:   state_next = rsm_pkg::ST_DIV_WAIT;
            rsm_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = rsm_pkg::ST_DIV_PUSH;
            end
            rsm_pkg::ST_DIV_PUSH:
            begin
                if (push)
                begin
                    if (div_idx_reg == last_idx)
                    begin
                        state_next = rsm_pkg::ST_LOAD;
                        fill_next  = '0;
                        max_next   = -16'sd32768;
                    end
                    else
                    begin
                        state_next   = rsm_pkg::ST_DIV_RD;
                        div_idx_next = div_idx_reg + AW'(1);
                    end
                end
            end
            default: state_next = rsm_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsm_pkg::ST_LOAD;
            fill_reg      <= '0;
            max_reg       <= -16'sd32768;
            rd_idx_reg    <= '0;
            div_idx_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            q_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            max_reg       <= max_next;
            rd_idx_reg    <= rd_idx_next;
            div_idx_reg   <= div_idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            q_valid_reg   <= rd_en;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (in_acc && store_ok)
            row_mem[fill_reg[AW-1:0]] <= sample;
        row_q_reg <= row_mem[rd_idx_reg[AW-1:0]];
        q_idx_reg <= rd_idx_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (exp_rsp.valid)
            e_mem[exp_rsp.idx] <= exp_rsp.e;
        e_q_reg <= e_mem[div_idx_reg];
    end

    // output register, saturate quotient to 16 bits
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prob_reg <= div_rsp.quo[rsm_pkg::QUO_W-1] ? 16'hFFFF : div_rsp.quo[15:0];
            last_reg <= (div_idx_reg == last_idx);
        end
    end

    assign out_valid = out_valid_reg;
    assign prob      = prob_reg;
    assign last_out  = last_reg;

    `RSM_ASSERT(a_fill_range, fill_reg <= CW'(rsm_pkg::MAX_ROW))
    `RSM_ASSERT_IMP(a_exp_in_pass, exp_rsp.valid, state_reg == rsm_pkg::ST_EXP)
    `RSM_ASSERT_IMP(a_div_done_wait, div_rsp.done, state_reg == rsm_pkg::ST_DIV_WAIT)
    `RSM_ASSERT_IMP(a_row_nonempty, state_reg != rsm_pkg::ST_LOAD, fill_reg != '0)
endmodule
`default_nettype wire

// ===== src/rsm_exp.sv =====
// ----------------------------------------------------------------------------
// rsm_exp
// Three-stage pipeline for e = 2^(-m*log2(e)) in Q1.15, tagged by index.
// ----------------------------------------------------------------------------
`default_nettype none
module rsm_exp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rsm_pkg::exp_req_t req,
    output rsm_pkg::exp_rsp_t      rsp
);
    logic                        v1_reg, v2_reg, v3_reg;
    logic [rsm_pkg::ADDR_W-1:0]  i1_reg, i2_reg, i3_reg;
    logic [32:0]                 u_reg;
    logic [8:0]                  n_reg;
    logic [15:0]                 tk_reg;
    logic [30:0]                 prod_reg;
    logic [15:0]                 e_reg;

    logic [3:0]  k;
    logic [10:0] dif;
    logic [31:0] corr;
    logic [15:0] v;
    logic [16:0] rnd;
    logic [16:0] sh;
    logic [15:0] e_next;

    always_comb
    begin
        k    = u_reg[23:20];
        dif  = 11'(rsm_pkg::pow2_tab({1'b0, k}) - rsm_pkg::pow2_tab(5'({1'b0, k}) + 5'd1));
        corr = {1'b0, prod_reg} + 32'd524288;
        v    = tk_reg - corr[31:20];
        rnd  = 17'd0;
        sh   = 17'd0;
        if (n_reg == 9'd0)
            e_next = v;
        else if (n_reg > 9'd16)
            e_next = 16'd0;
        else
        begin
            rnd    = 17'd1 << (n_reg[4:0] - 5'd1);
            sh     = ({1'b0, v} + rnd) >> n_reg[4:0];
            e_next = sh[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= {17'd0, req.m} * {16'd0, rsm_pkg::LOG2E_Q16};
        i1_reg   <= req.idx;
        n_reg    <= u_reg[32:24];
        tk_reg   <= rsm_pkg::pow2_tab({1'b0, k});
        prod_reg <= {20'd0, dif} * {11'd0, u_reg[19:0]};
        i2_reg   <= i1_reg;
        e_reg    <= e_next;
        i3_reg   <= i2_reg;
    end

    assign rsp.valid = v3_reg;
    assign rsp.idx   = i3_reg;
    assign rsp.e     = e_reg;
endmodule
`default_nettype wire

// ===== src/rsm_div.sv =====
// ----------------------------------------------------------------------------
// rsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rsm_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rsm_pkg::div_req_t req,
    output rsm_pkg::div_rsp_t      rsp
);
    localparam int LOW_W = rsm_pkg::QUO_W;

    logic                       busy_reg, done_reg;
    logic [4:0]                 cnt_reg;
    logic [rsm_pkg::SUM_W-1:0]  rem_reg, den_reg;
    logic [LOW_W-1:0]           sh_reg;
    logic [rsm_pkg::QUO_W-1:0]  quo_reg;
    logic [rsm_pkg::SUM_W:0]    trial;
    logic                       take;

    // Quotient stays below 2^17, so the upper numerator bits are already below den.
    always_comb
    begin
        trial = {rem_reg, sh_reg[LOW_W-1]};
        take  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(LOW_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= rsm_pkg::SUM_W'(req.num[rsm_pkg::NUM_W-1:LOW_W]);
            sh_reg  <= req.num[LOW_W-1:0];
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rsm_pkg::SUM_W'(trial - {1'b0, den_reg})
                            : trial[rsm_pkg::SUM_W-1:0];
            sh_reg  <= {sh_reg[LOW_W-2:0], 1'b0};
            quo_reg <= {quo_reg[rsm_pkg::QUO_W-2:0], take};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire
